/* rtl/urla_pkg.sv */
// package for the uart receive line assembler: payload types, codes and defaults
`default_nettype none

package urla_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 1024;
  localparam int LINE_DEPTH_DEFAULT  = 1024;

  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECEIVE   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_LINE = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE_LINE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

  // characters the line assembler reacts to
  localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] line_index;
  } urla_item_t;

  typedef struct packed {
    logic              pop_valid;
    logic [BYTE_W-1:0] pop_byte;
    logic [BYTE_W-1:0] line_byte;
    logic              line_ready;
    logic              byte_queued;
  } urla_result_t;

  // strobes for the line assembler, valid on the cycle a transaction is accepted
  typedef struct packed {
    logic               receive;
    logic               read;
    logic               take;
    logic               clear;
    logic [BYTE_W-1:0]  rx_byte;
    logic [INDEX_W-1:0] line_index;
  } urla_line_ctl_t;

endpackage

`default_nettype wire

/* rtl/uart_rx_line_assembler_core.sv */
// top level: receive byte queue plus line assembler behind a two-stage result path
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------
//  item    | in        | item_valid/stall    | urla_item_t (op, byte, index)
//  result  | out       | result_valid/stall  | urla_result_t (one per item)
//
// one transaction per cycle sustained while the result is not stalled; each result passes
// through the read stage (synchronous queue/line memory read) and then the output register.
// reset clears pointers, fill index and flags; the line store tracks its written
// extent, so no clearing pass is run and items are taken right after reset.
// a stalled result holds the read stage; item_stall rises only when both stages are full.
`default_nettype none

module uart_rx_line_assembler_core #(
  parameter int QUEUE_DEPTH = urla_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int LINE_DEPTH  = urla_pkg::LINE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire urla_pkg::urla_item_t  item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output urla_pkg::urla_result_t     result
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam logic [QW-1:0] Q_LAST = QW'(QUEUE_DEPTH - 1);

  // ring queue storage, one slot always left empty
  logic [urla_pkg::BYTE_W-1:0] qmem [QUEUE_DEPTH];
  logic [QW-1:0]               rp;
  logic [QW-1:0]               wp;
  logic [QW-1:0]               wp_inc;
  logic [QW-1:0]               rp_inc;
  logic [urla_pkg::BYTE_W-1:0] q_rdata;

  logic item_accept;
  logic is_receive;
  logic is_pop;
  logic push_ok;
  logic pop_ok;

  // read stage: memory data lands here in the cycle after acceptance
  logic s1_valid;
  logic s1_move;
  logic s1_pop_valid;
  logic s1_queued;
  logic s1_read;

  urla_pkg::urla_line_ctl_t    line_ctl;
  logic                        line_ready;
  logic [urla_pkg::BYTE_W-1:0] line_byte;

  // the read stage can only drain when the output register is free or being taken
  assign s1_move     = s1_valid && !(result_valid && result_stall);
  assign item_stall  = s1_valid && result_valid && result_stall;
  assign item_accept = item_valid && !item_stall;

  assign is_receive = item_accept && (item.operation == urla_pkg::OP_RECEIVE);
  assign is_pop     = item_accept && (item.operation == urla_pkg::OP_POP);

  assign wp_inc  = (wp == Q_LAST) ? '0 : wp + QW'(1);
  assign rp_inc  = (rp == Q_LAST) ? '0 : rp + QW'(1);
  assign push_ok = (wp_inc != rp);
  assign pop_ok  = (rp != wp);

  // line assembler strobes
  always_comb begin
    line_ctl            = '0;
    line_ctl.rx_byte    = item.rx_byte;
    line_ctl.line_index = item.line_index;
    if (item_accept) begin
      unique case (item.operation)
        urla_pkg::OP_RECEIVE:   line_ctl.receive = 1'b1;
        urla_pkg::OP_READ_LINE: line_ctl.read    = 1'b1;
        urla_pkg::OP_TAKE_LINE: line_ctl.take    = 1'b1;
        urla_pkg::OP_CLEAR:     line_ctl.clear   = 1'b1;
        default:                line_ctl.receive = 1'b0;
      endcase
    end
  end

  urla_line #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line (
    .clk        (clk),
    .rst        (rst),
    .ctl        (line_ctl),
    .line_ready (line_ready),
    .line_byte  (line_byte)
  );

  // queue pointers; clear empties the ring without touching stored bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else if (item_accept && (item.operation == urla_pkg::OP_CLEAR)) begin
      rp <= '0;
      wp <= '0;
    end else begin
      if (is_receive && push_ok) begin
        wp <= wp_inc;
      end
      if (is_pop && pop_ok) begin
        rp <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_receive && push_ok) begin
      qmem[wp] <= item.rx_byte;
    end
  end

  // pop data holds until the next pop so a stalled result keeps its byte
  always_ff @(posedge clk) begin
    if (is_pop && pop_ok) begin
      q_rdata <= qmem[rp];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_pop_valid <= is_pop && pop_ok;
      s1_queued    <= is_receive && push_ok;
      s1_read      <= line_ctl.read;
    end
  end

  // output register; ready flag read here is the value after the read-stage item,
  // since a newer item is only accepted on the edge this stage drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // line byte only reported for a line read, zero for every other operation
  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.pop_valid   <= s1_pop_valid;
      result.pop_byte    <= s1_pop_valid ? q_rdata : urla_pkg::CH_NUL;
      result.line_byte   <= s1_read ? line_byte : urla_pkg::CH_NUL;
      result.line_ready  <= line_ready;
      result.byte_queued <= s1_queued;
    end
  end

`ifndef SYNTHESIS
  a_push_leaves_nonempty: assert property (@(posedge clk) disable iff (rst)
    (is_receive && push_ok) |=> (rp != wp))
    else $error("queue empty right after a push");
  a_clear_empties_queue: assert property (@(posedge clk) disable iff (rst)
    (item_accept && (item.operation == urla_pkg::OP_CLEAR)) |=> ((rp == '0) && (wp == '0)))
    else $error("queue pointers not reset by clear");
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |-> !item_accept)
    else $error("item accepted while read stage is blocked");
`endif

endmodule

`default_nettype wire

/* rtl/urla_line.sv */
// line assembler: line store memory, fill index, ready and linefeed skip flags
`default_nettype none

module urla_line #(
  parameter int LINE_DEPTH = urla_pkg::LINE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire urla_pkg::urla_line_ctl_t    ctl,
  output logic                             line_ready,
  output logic [urla_pkg::BYTE_W-1:0]      line_byte
);

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int CW    = $clog2(LINE_DEPTH + 1);
  localparam int CMP_W = (CW > urla_pkg::INDEX_W) ? CW : urla_pkg::INDEX_W;
  localparam logic [AW-1:0] FILL_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0] ADDR_ONE  = AW'(1);

  logic [urla_pkg::BYTE_W-1:0] mem [LINE_DEPTH];

  logic [AW-1:0] fill, fill_next;
  logic [CW-1:0] count, count_next;    // entries 0..count-1 have been written, save entry one under zero1
  logic          zero1, zero1_next;    // entry one reads as zero after a prompt
  logic          ready, ready_next;
  logic          skip, skip_next;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [urla_pkg::BYTE_W-1:0] wdata;

  logic [CW-1:0]               fill_ext;
  logic [CMP_W-1:0]            idx_ext;
  logic                        hit;
  logic                        hit_q;
  logic [urla_pkg::BYTE_W-1:0] rdata;

  assign fill_ext = CW'(fill) + CW'(1);
  assign idx_ext  = CMP_W'(ctl.line_index);
  assign hit      = (idx_ext < CMP_W'(count)) &&
                    !(zero1 && (idx_ext == CMP_W'(1)));

  always_comb begin
    fill_next  = fill;
    count_next = count;
    zero1_next = zero1;
    ready_next = ready;
    skip_next  = skip;
    we         = 1'b0;
    waddr      = fill;
    wdata      = urla_pkg::CH_NUL;
    if (ctl.receive) begin
      priority if (ctl.rx_byte == urla_pkg::CH_PROMPT) begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = urla_pkg::CH_PROMPT;
        zero1_next = 1'b1;
        count_next = (count < CW'(2)) ? CW'(2) : count;
        fill_next  = '0;
        ready_next = 1'b1;
        skip_next  = 1'b0;
      end else if ((ctl.rx_byte == urla_pkg::CH_LF) && skip) begin
        skip_next = 1'b0;
      end else if ((ctl.rx_byte == urla_pkg::CH_CR) ||
                   (ctl.rx_byte == urla_pkg::CH_LF)) begin
        we         = 1'b1;
        count_next = (count < fill_ext) ? fill_ext : count;
        if (fill == ADDR_ONE) begin
          zero1_next = 1'b0;
        end
        fill_next  = '0;
        ready_next = 1'b1;
        skip_next  = (ctl.rx_byte == urla_pkg::CH_CR);
      end else if (fill < FILL_LAST) begin
        we         = 1'b1;
        wdata      = ctl.rx_byte;
        count_next = (count < fill_ext) ? fill_ext : count;
        if (fill == ADDR_ONE) begin
          zero1_next = 1'b0;
        end
        fill_next  = fill + AW'(1);
        skip_next  = 1'b0;
      end
    end else if (ctl.take) begin
      ready_next = 1'b0;
    end else if (ctl.clear) begin
      we         = 1'b1;
      waddr      = '0;
      count_next = (count < CW'(1)) ? CW'(1) : count;
      fill_next  = '0;
      ready_next = 1'b0;
      skip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
      zero1 <= 1'b0;
      ready <= 1'b0;
      skip  <= 1'b0;
    end else begin
      fill  <= fill_next;
      count <= count_next;
      zero1 <= zero1_next;
      ready <= ready_next;
      skip  <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read so a stalled result keeps its byte
  always_ff @(posedge clk) begin
    if (ctl.read) begin
      rdata <= mem[idx_ext[AW-1:0]];
      hit_q <= hit;
    end
  end

  assign line_ready = ready;
  assign line_byte  = hit_q ? rdata : urla_pkg::CH_NUL;

`ifndef SYNTHESIS
  a_fill_within_count: assert property (@(posedge clk) disable iff (rst)
    CW'(fill) <= count)
    else $error("fill index beyond written extent");
  a_zero1_needs_two: assert property (@(posedge clk) disable iff (rst)
    zero1 |-> (count >= CW'(2)))
    else $error("entry one override without prompt extent");
  a_take_clears_ready: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> !ready)
    else $error("ready still set after take line");
`endif

endmodule

`default_nettype wire
